@@ rtl/tdvb_pkg.sv @@
// shared types and constants of the touch drag vertical band filter
package tdvb_pkg;

   localparam int PIX_WIDTH       = 16;
   localparam int SIZE_WIDTH      = 12;
   localparam int LIMIT_WIDTH     = 15;
   localparam int POS_WIDTH       = 18;
   localparam int CSR_INDEX_WIDTH = 1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DRIFT_UP   = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DRIFT_DOWN = 1'b1;

   localparam logic [LIMIT_WIDTH-1:0] DRIFT_RESET = 15'd20;

   localparam logic STATUS_OK         = 1'b0;
   localparam logic STATUS_UNEXPECTED = 1'b1;

   typedef enum logic [1:0] {
      REQ_SET_LOCATION = 2'd0,
      REQ_START_DRAG   = 2'd1,
      REQ_DRAG_SAMPLE  = 2'd2,
      REQ_END_DRAG     = 2'd3
   } req_kind_type;

   typedef struct packed {
      logic [SIZE_WIDTH-1:0]       gripper_diameter;
      logic [SIZE_WIDTH-1:0]       line_height;
      logic signed [PIX_WIDTH-1:0] point_y;
      logic signed [PIX_WIDTH-1:0] point_x;
   } req_data_type;

   typedef struct packed {
      logic [3:0]                  pad;
      logic signed [POS_WIDTH-1:0] pos_y;
      logic signed [POS_WIDTH-1:0] pos_x;
   } rsp_data_type;

   typedef struct packed {
      logic [LIMIT_WIDTH-1:0] up;
      logic [LIMIT_WIDTH-1:0] down;
   } drift_limits_type;

endpackage

@@ rtl/touch_drag_vertical_band_filter.sv @@
// Touch drag vertical band filter: every request beat (set gripper location, start drag,
// drag sample, end drag) yields exactly one response beat with a status in rsp_tuser and
// the filtered anchor position in rsp_tdata. A request is registered on accept, its
// whole state update is combinational in the tracking logic, and the response is
// held in an output register behind the request register, so one request is taken
// every cycle while the response side keeps up; the tracking state loop closes within
// each update. The user must write drift limits through the csr channel only while no
// request is in flight; the block itself does not enforce it. Both reset to 20 pixels.
module touch_drag_vertical_band_filter #(
   parameter int COORD_WIDTH = 18
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  tdvb_pkg::req_data_type               req_tdata,  // point_x, point_y, line_height, gripper_diameter
   input  tdvb_pkg::req_kind_type               req_tuser,  // req_type
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output tdvb_pkg::rsp_data_type               rsp_tdata,  // pos_x, pos_y, zero pad
   output logic                                 rsp_tuser,  // status
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tdvb_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [tdvb_pkg::LIMIT_WIDTH-1:0]     csr_data
);
   import tdvb_pkg::*;

   logic             in_valid_ff;
   req_kind_type     in_kind_ff;
   req_data_type     in_data_ff;
   logic             rsp_valid_ff;
   logic             rsp_status_ff;
   rsp_data_type     rsp_data_ff;

   logic             advance;
   logic             fire;
   drift_limits_type limits;
   logic             step_status;
   logic signed [POS_WIDTH-1:0] step_pos_x;
   logic signed [POS_WIDTH-1:0] step_pos_y;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   tdvb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .limits    (limits)
   );

   tdvb_track #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_track (
      .clock    (clock),
      .reset    (reset),
      .step_en  (fire),
      .req_kind (in_kind_ff),
      .req_data (in_data_ff),
      .limits   (limits),
      .status   (step_status),
      .pos_x    (step_pos_x),
      .pos_y    (step_pos_y)
   );

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_kind_ff <= req_tuser;
         in_data_ff <= req_tdata;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_status_ff     <= step_status;
         rsp_data_ff.pad   <= '0;
         rsp_data_ff.pos_x <= step_pos_x;
         rsp_data_ff.pos_y <= step_pos_y;
      end
   end

endmodule

@@ rtl/tdvb_csr.sv @@
// drift limit registers behind the configuration write channel
module tdvb_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tdvb_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [tdvb_pkg::LIMIT_WIDTH-1:0]     csr_data,
   output tdvb_pkg::drift_limits_type           limits
);
   import tdvb_pkg::*;

   drift_limits_type limits_ff;
   drift_limits_type limits_in;

   assign csr_ready = 1'b1;
   assign limits    = limits_ff;

   always_comb begin
      limits_in = limits_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DRIFT_UP:   limits_in.up   = csr_data;
            CSR_DRIFT_DOWN: limits_in.down = csr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.up   <= DRIFT_RESET;
         limits_ff.down <= DRIFT_RESET;
      end else begin
         limits_ff <= limits_in;
      end
   end

endmodule

@@ rtl/tdvb_track.sv @@
// drag tracking state and the combinational band filter update
module tdvb_track #(
   parameter int COORD_WIDTH = 18
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    step_en,
   input  tdvb_pkg::req_kind_type                  req_kind,
   input  tdvb_pkg::req_data_type                  req_data,
   input  tdvb_pkg::drift_limits_type              limits,
   output logic                                    status,
   output logic signed [tdvb_pkg::POS_WIDTH-1:0]   pos_x,
   output logic signed [tdvb_pkg::POS_WIDTH-1:0]   pos_y
);
   import tdvb_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int XW = COORD_WIDTH + 2;

   logic                   drag_active_ff, drag_active_in;
   logic                   has_moved_ff, has_moved_in;
   logic signed [CW-1:0]   start_x_ff, start_x_in;
   logic signed [CW-1:0]   start_y_ff, start_y_in;
   logic signed [CW-1:0]   anchor_x_ff, anchor_x_in;
   logic signed [CW-1:0]   anchor_y_ff, anchor_y_in;
   logic signed [CW-1:0]   contact_ff, contact_in;
   logic signed [CW-1:0]   expanded_ff, expanded_in;
   logic [SIZE_WIDTH-1:0]  diameter_ff, diameter_in;
   logic signed [CW-1:0]   last_x_ff, last_x_in;
   logic signed [CW-1:0]   last_y_ff, last_y_in;
   logic [SIZE_WIDTH-1:0]  line_height_ff, line_height_in;

   logic signed [CW-1:0]   px, py;
   logic signed [XW-1:0]   centre_diff;
   logic                   point_changed;
   logic                   moved;
   logic signed [CW-1:0]   step_size;
   logic signed [CW-1:0]   start_expanded;
   logic signed [CW-1:0]   start_shifted;
   logic signed [CW-1:0]   anchor_shifted;
   logic                   band_now, band_expanded, band_shifted;
   logic signed [CW-1:0]   res_x, res_y, ay;

   function automatic logic in_band(input logic signed [CW-1:0] start_v,
                                    input logic signed [CW-1:0] last_v,
                                    input drift_limits_type lim);
      logic signed [CW:0] up;
      logic signed [CW:0] down;
      up   = (CW+1)'(start_v) - (CW+1)'(last_v);
      down = -up;
      return (up <= $signed({{(CW+1-LIMIT_WIDTH){1'b0}}, lim.up}))
          && (down <= $signed({{(CW+1-LIMIT_WIDTH){1'b0}}, lim.down}));
   endfunction

   assign px = CW'(req_data.point_x);
   assign py = CW'(req_data.point_y);

   assign centre_diff = XW'(anchor_y_ff) + $signed({{(XW-SIZE_WIDTH){1'b0}}, diameter_ff})
                        - XW'(py);

   assign point_changed = (px != last_x_ff) || (py != last_y_ff);
   assign last_x_in     = (step_en && req_kind == REQ_DRAG_SAMPLE && drag_active_ff
                           && point_changed) ? px : last_x_ff;
   assign last_y_in     = (step_en && req_kind == REQ_DRAG_SAMPLE && drag_active_ff
                           && point_changed) ? py : last_y_ff;

   assign moved = has_moved_ff || (last_x_in != start_x_ff) || (last_y_in != start_y_ff);

   assign step_size = $signed({{(CW-SIZE_WIDTH){1'b0}},
                               point_changed ? req_data.line_height : line_height_ff});

   assign start_expanded = start_y_ff + expanded_ff;
   assign start_shifted  = (start_y_ff < last_y_in) ? start_y_ff + step_size
                                                    : start_y_ff - step_size;
   assign anchor_shifted = (start_y_ff < last_y_in) ? anchor_y_ff + step_size
                                                    : anchor_y_ff - step_size;

   assign band_now      = in_band(start_y_ff, last_y_in, limits);
   assign band_expanded = in_band(start_expanded, last_y_in, limits);
   assign band_shifted  = in_band(start_shifted, last_y_in, limits);

   always_comb begin
      drag_active_in = drag_active_ff;
      has_moved_in   = has_moved_ff;
      start_x_in     = start_x_ff;
      start_y_in     = start_y_ff;
      anchor_x_in    = anchor_x_ff;
      anchor_y_in    = anchor_y_ff;
      contact_in     = contact_ff;
      expanded_in    = expanded_ff;
      diameter_in    = diameter_ff;
      line_height_in = line_height_ff;
      status         = STATUS_OK;
      res_x          = '0;
      res_y          = '0;
      ay             = last_y_in;
      case (req_kind)
         REQ_SET_LOCATION: begin
            anchor_x_in = px;
            anchor_y_in = py;
            diameter_in = req_data.gripper_diameter;
            contact_in  = py - start_y_ff;
         end
         REQ_START_DRAG: begin
            if (drag_active_ff) begin
               status = STATUS_UNEXPECTED;
            end else begin
               drag_active_in = 1'b1;
               has_moved_in   = 1'b0;
               expanded_in    = (centre_diff > 0) ? centre_diff[CW-1:0] : '0;
               contact_in     = anchor_y_ff - py;
               start_x_in     = px;
               start_y_in     = py;
               line_height_in = req_data.line_height;
            end
         end
         REQ_DRAG_SAMPLE: begin
            if (!drag_active_ff) begin
               status = STATUS_UNEXPECTED;
            end else begin
               if (point_changed) begin
                  line_height_in = req_data.line_height;
               end
               has_moved_in = moved;
               if (band_now) begin
                  ay = start_y_ff;
               end else if (expanded_ff != '0) begin
                  start_y_in  = start_expanded;
                  contact_in  = anchor_y_ff - start_expanded;
                  expanded_in = '0;
                  if (band_expanded) begin
                     ay = start_expanded;
                  end
               end else begin
                  start_y_in  = start_shifted;
                  anchor_y_in = anchor_shifted;
                  if (band_shifted) begin
                     ay = start_shifted;
                  end
               end
               res_x = moved ? last_x_in : anchor_x_ff;
               res_y = ay + contact_in;
            end
         end
         default: begin
            status         = drag_active_ff ? STATUS_OK : STATUS_UNEXPECTED;
            drag_active_in = 1'b0;
         end
      endcase
   end

   assign pos_x = POS_WIDTH'(res_x);
   assign pos_y = POS_WIDTH'(res_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         drag_active_ff <= 1'b0;
         has_moved_ff   <= 1'b0;
         start_x_ff     <= '0;
         start_y_ff     <= '0;
         anchor_x_ff    <= '0;
         anchor_y_ff    <= '0;
         contact_ff     <= '0;
         expanded_ff    <= '0;
         diameter_ff    <= '0;
         last_x_ff      <= '0;
         last_y_ff      <= '0;
         line_height_ff <= '0;
      end else if (step_en) begin
         drag_active_ff <= drag_active_in;
         has_moved_ff   <= has_moved_in;
         start_x_ff     <= start_x_in;
         start_y_ff     <= start_y_in;
         anchor_x_ff    <= anchor_x_in;
         anchor_y_ff    <= anchor_y_in;
         contact_ff     <= contact_in;
         expanded_ff    <= expanded_in;
         diameter_ff    <= diameter_in;
         last_x_ff      <= last_x_in;
         last_y_ff      <= last_y_in;
         line_height_ff <= line_height_in;
      end
   end

endmodule
